### design/cctd_pkg.sv
// Shared types, codes and denomination tables for the cash till change dispenser.
package cctd_pkg;

    localparam int REAL_DENOMS = 7;
    localparam int DEP_W       = 8;
    localparam int AMT_W       = 16;
    localparam int REQ_AMT_W   = AMT_W + 1;
    localparam int TOTAL_W     = 26;
    localparam int IDX_W       = 3;
    localparam int DIDX_W      = 4;
    localparam int VAL_W       = 9;
    localparam int RCP_SHIFT   = 25;
    localparam int RCP_W       = 26;

    typedef logic [1:0]        t_action;
    typedef logic [1:0]        t_status;
    typedef logic [DIDX_W-1:0] t_didx;

    localparam t_action ACT_DEPOSIT  = 2'd0;
    localparam t_action ACT_CHECK    = 2'd1;
    localparam t_action ACT_DISPENSE = 2'd2;
    localparam t_action ACT_NONE     = 2'd3;

    localparam t_status ST_OK      = 2'd0;
    localparam t_status ST_NOFUNDS = 2'd1;
    localparam t_status ST_INEXACT = 2'd2;

    // Note value per denomination index; slots past the seventh hold nothing.
    function automatic logic [VAL_W-1:0] denom_value(input t_didx idx);
        logic [VAL_W-1:0] v;
        case (idx)
            4'd0:    v = 9'd1;
            4'd1:    v = 9'd5;
            4'd2:    v = 9'd10;
            4'd3:    v = 9'd50;
            4'd4:    v = 9'd100;
            4'd5:    v = 9'd200;
            4'd6:    v = 9'd500;
            default: v = 9'd0;
        endcase
        return v;
    endfunction

    // ceil(2^RCP_SHIFT / value): exact floor quotient for any 16-bit amount.
    function automatic logic [RCP_W-1:0] denom_recip(input t_didx idx);
        logic [RCP_W-1:0] m;
        case (idx)
            4'd0:    m = 26'd33554432;
            4'd1:    m = 26'd6710887;
            4'd2:    m = 26'd3355444;
            4'd3:    m = 26'd671089;
            4'd4:    m = 26'd335545;
            4'd5:    m = 26'd167773;
            4'd6:    m = 26'd67109;
            default: m = 26'd0;
        endcase
        return m;
    endfunction

endpackage

### design/cctd_ifs.sv
// Request and result channel interfaces of the cash till change dispenser.
interface cctd_req_if
    import cctd_pkg::*;
;
    logic                        valid;
    logic                        ready;
    t_action                     action;
    logic signed [REQ_AMT_W-1:0] change_amount;
    logic [DEP_W-1:0]            deposit_count_1;
    logic [DEP_W-1:0]            deposit_count_5;
    logic [DEP_W-1:0]            deposit_count_10;
    logic [DEP_W-1:0]            deposit_count_50;
    logic [DEP_W-1:0]            deposit_count_100;
    logic [DEP_W-1:0]            deposit_count_200;
    logic [DEP_W-1:0]            deposit_count_500;

    modport source (
        output valid, action, change_amount,
               deposit_count_1, deposit_count_5, deposit_count_10, deposit_count_50,
               deposit_count_100, deposit_count_200, deposit_count_500,
        input  ready
    );
    modport sink (
        input  valid, action, change_amount,
               deposit_count_1, deposit_count_5, deposit_count_10, deposit_count_50,
               deposit_count_100, deposit_count_200, deposit_count_500,
        output ready
    );
endinterface

interface cctd_rsp_if
    import cctd_pkg::*;
;
    logic               valid;
    logic               ready;
    t_status            status;
    logic [IDX_W-1:0]   note_index;
    logic [AMT_W-1:0]   notes_given;
    logic [AMT_W-1:0]   amount_left;
    logic [TOTAL_W-1:0] till_total;
    logic               last_result;

    modport source (
        output valid, status, note_index, notes_given, amount_left, till_total, last_result,
        input  ready
    );
    modport sink (
        input  valid, status, note_index, notes_given, amount_left, till_total, last_result,
        output ready
    );
endinterface

### design/cash_till_change_dispenser.sv
// Cash till change dispenser: note counts in a memory, greedy change walk, one unit shared.
//
//  channel  dir  modport  contents
//  i_req    in   sink     action, change_amount, seven deposit counts
//  o_rsp    out  source   status, note_index, notes_given, amount_left, till_total, last_result
//
// One request at a time; the count memory has one read and one write port.
// Deposit: one read-modify-write per count, then the result.
// Check/dispense: quotient, then subtract per count, then the result; a dispense that takes
// notes emits instead one result per denomination used; negative or unused: result at once.
// Reset clears all counts at once through per-entry valid bits; no clearing pass.
// A stalled result channel holds the walk only at the result-loading steps.
module cash_till_change_dispenser
    import cctd_pkg::*;
#(
    parameter int NUM_DENOMS  = 7,
    parameter int COUNT_WIDTH = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    cctd_req_if.sink   i_req,
    cctd_rsp_if.source o_rsp
);

    localparam int IW    = $clog2(NUM_DENOMS);
    localparam int CW    = COUNT_WIDTH;
    localparam int CMP_W = (CW > AMT_W) ? CW : AMT_W;
    localparam int QP_W  = AMT_W + RCP_W;
    localparam int SP_W  = AMT_W + VAL_W;
    localparam int DV_W  = DEP_W + VAL_W;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DEP  = 3'd1;
    localparam logic [2:0] S_CALC = 3'd2;
    localparam logic [2:0] S_SUB  = 3'd3;
    localparam logic [2:0] S_FIN  = 3'd4;
    localparam logic [2:0] S_EMRD = 3'd5;
    localparam logic [2:0] S_EMWR = 3'd6;

    logic [2:0]            r_state, n_state;
    logic [IW-1:0]         r_idx, n_idx;
    logic                  r_dispense, n_dispense;
    logic                  r_walk, n_walk;
    logic                  r_neg, n_neg;
    logic [AMT_W-1:0]      r_rem, n_rem;
    logic [DEP_W-1:0]      r_dep [REAL_DENOMS];
    logic [DEP_W-1:0]      n_dep [REAL_DENOMS];
    logic [TOTAL_W-1:0]    r_total, n_total;
    logic [NUM_DENOMS-1:0] r_used, n_used;
    logic [AMT_W-1:0]      r_take, n_take;
    logic [CW-1:0]         r_cnt, n_cnt;
    logic                  r_ovalid, n_ovalid;

    logic [CW-1:0]         r_cnt_mem [NUM_DENOMS];
    logic [AMT_W-1:0]      r_tk_mem  [NUM_DENOMS];
    logic [NUM_DENOMS-1:0] r_vld;
    logic [CW-1:0]         r_rd_cnt;
    logic                  r_rd_vld;
    logic [AMT_W-1:0]      r_tk_rd;

    logic [1:0]            r_o_status;
    logic [IDX_W-1:0]      r_o_index;
    logic [AMT_W-1:0]      r_o_given;
    logic [AMT_W-1:0]      r_o_left;
    logic [TOTAL_W-1:0]    r_o_total;
    logic                  r_o_last;

    logic                  w_we, w_re, w_tk_we, w_tk_re;
    logic [IW-1:0]         w_raddr;
    logic [CW-1:0]         w_wdata;
    logic                  w_load;
    t_status               w_ld_status;
    logic [IDX_W-1:0]      w_ld_index;
    logic [AMT_W-1:0]      w_ld_given;
    logic [AMT_W-1:0]      w_ld_left;
    logic                  w_ld_last;
    logic                  w_slot_free;
    t_status               w_status;
    logic [CW-1:0]         w_cnt;
    logic [VAL_W-1:0]      w_val;
    logic [RCP_W-1:0]      w_rcp;
    logic [DEP_W-1:0]      w_dep;
    logic [CW:0]           w_sum;
    logic [CW-1:0]         w_new;
    logic [DEP_W-1:0]      w_delta;
    logic [DV_W-1:0]       w_dep_val;
    logic [QP_W-1:0]       w_qprod;
    logic [AMT_W-1:0]      w_quot;
    logic [AMT_W-1:0]      w_take;
    logic [SP_W-1:0]       w_sub_prod;
    logic [IW-1:0]         w_hi;
    logic [NUM_DENOMS-1:0] w_used_left;

    assign i_req.ready = (r_state == S_IDLE);

    assign o_rsp.valid       = r_ovalid;
    assign o_rsp.status      = r_o_status;
    assign o_rsp.note_index  = r_o_index;
    assign o_rsp.notes_given = r_o_given;
    assign o_rsp.amount_left = r_o_left;
    assign o_rsp.till_total  = r_o_total;
    assign o_rsp.last_result = r_o_last;

    assign w_slot_free = !r_ovalid || o_rsp.ready;
    assign w_cnt       = r_rd_vld ? r_rd_cnt : '0;
    assign w_val       = denom_value(DIDX_W'(r_idx));
    assign w_rcp       = denom_recip(DIDX_W'(r_idx));

    always_comb begin
        w_status = ST_OK;
        if (r_neg) begin
            w_status = ST_NOFUNDS;
        end else if (r_walk && (r_rem != '0)) begin
            w_status = ST_INEXACT;
        end
    end

    // deposit count of the current denomination
    always_comb begin
        w_dep = '0;
        for (int k = 0; k < REAL_DENOMS; k++) begin
            if ((k < NUM_DENOMS) && (int'(r_idx) == k)) begin
                w_dep = r_dep[k];
            end
        end
    end

    // saturating add; a carry means the count passed its maximum
    assign w_sum     = {1'b0, w_cnt} + (CW + 1)'(w_dep);
    assign w_new     = w_sum[CW] ? '1 : w_sum[CW-1:0];
    assign w_delta   = DEP_W'(w_new - w_cnt);
    assign w_dep_val = DV_W'(w_delta) * DV_W'(w_val);

    // greedy take: min(count, remaining / value) via the reciprocal table
    assign w_qprod = QP_W'(r_rem) * QP_W'(w_rcp);
    assign w_quot  = w_qprod[RCP_SHIFT +: AMT_W];
    assign w_take  = (CMP_W'(w_quot) <= CMP_W'(w_cnt)) ? w_quot : AMT_W'(w_cnt);

    assign w_sub_prod = SP_W'(r_take) * SP_W'(w_val);

    // highest denomination still to be reported
    always_comb begin
        w_hi = '0;
        for (int k = 0; k < NUM_DENOMS; k++) begin
            if (r_used[k]) begin
                w_hi = IW'(k);
            end
        end
    end

    always_comb begin
        w_used_left        = r_used;
        w_used_left[r_idx] = 1'b0;
    end

    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_dispense  = r_dispense;
        n_walk      = r_walk;
        n_neg       = r_neg;
        n_rem       = r_rem;
        n_dep       = r_dep;
        n_total     = r_total;
        n_used      = r_used;
        n_take      = r_take;
        n_cnt       = r_cnt;
        w_we        = 1'b0;
        w_wdata     = w_new;
        w_re        = 1'b0;
        w_raddr     = r_idx;
        w_tk_we     = 1'b0;
        w_tk_re     = 1'b0;
        w_load      = 1'b0;
        w_ld_status = w_status;
        w_ld_index  = '0;
        w_ld_given  = '0;
        w_ld_left   = '0;
        w_ld_last   = 1'b1;

        unique case (r_state)
            S_IDLE: begin
                if (i_req.valid) begin
                    n_dispense = (i_req.action == ACT_DISPENSE);
                    n_rem      = i_req.change_amount[AMT_W-1:0];
                    n_neg      = 1'b0;
                    n_walk     = 1'b0;
                    n_used     = '0;
                    n_dep[0]   = i_req.deposit_count_1;
                    n_dep[1]   = i_req.deposit_count_5;
                    n_dep[2]   = i_req.deposit_count_10;
                    n_dep[3]   = i_req.deposit_count_50;
                    n_dep[4]   = i_req.deposit_count_100;
                    n_dep[5]   = i_req.deposit_count_200;
                    n_dep[6]   = i_req.deposit_count_500;
                    case (i_req.action) inside
                        ACT_DEPOSIT: begin
                            n_idx   = '0;
                            w_re    = 1'b1;
                            w_raddr = '0;
                            n_state = S_DEP;
                        end
                        ACT_CHECK, ACT_DISPENSE: begin
                            if (i_req.change_amount[AMT_W]) begin
                                n_neg   = 1'b1;
                                n_state = S_FIN;
                            end else begin
                                n_walk  = 1'b1;
                                n_idx   = IW'(NUM_DENOMS - 1);
                                w_re    = 1'b1;
                                w_raddr = IW'(NUM_DENOMS - 1);
                                n_state = S_CALC;
                            end
                        end
                        default: begin
                            n_state = S_FIN;
                        end
                    endcase
                end
            end
            S_DEP: begin
                w_we    = 1'b1;
                w_wdata = w_new;
                n_total = r_total + TOTAL_W'(w_dep_val);
                if (r_idx == IW'(NUM_DENOMS - 1)) begin
                    n_state = S_FIN;
                end else begin
                    n_idx   = r_idx + IW'(1);
                    w_re    = 1'b1;
                    w_raddr = r_idx + IW'(1);
                end
            end
            S_CALC: begin
                n_take  = w_take;
                n_cnt   = w_cnt;
                n_state = S_SUB;
            end
            S_SUB: begin
                n_rem = r_rem - w_sub_prod[AMT_W-1:0];
                if (r_dispense) begin
                    w_we    = 1'b1;
                    w_wdata = r_cnt - CW'(r_take);
                    w_tk_we = 1'b1;
                    n_total = r_total - TOTAL_W'(w_sub_prod);
                    if (r_take != '0) begin
                        n_used[r_idx] = 1'b1;
                    end
                end
                if (r_idx == '0) begin
                    n_state = (r_dispense && (n_used != '0)) ? S_EMRD : S_FIN;
                end else begin
                    n_idx   = r_idx - IW'(1);
                    w_re    = 1'b1;
                    w_raddr = r_idx - IW'(1);
                    n_state = S_CALC;
                end
            end
            S_FIN: begin
                if (w_slot_free) begin
                    w_load    = 1'b1;
                    w_ld_left = r_walk ? r_rem : '0;
                    n_state   = S_IDLE;
                end
            end
            S_EMRD: begin
                w_tk_re = 1'b1;
                n_idx   = w_hi;
                n_state = S_EMWR;
            end
            S_EMWR: begin
                if (w_slot_free) begin
                    w_load     = 1'b1;
                    w_ld_index = IDX_W'(r_idx);
                    w_ld_given = r_tk_rd;
                    w_ld_left  = r_rem;
                    w_ld_last  = (w_used_left == '0);
                    n_used     = w_used_left;
                    n_state    = (w_used_left == '0) ? S_IDLE : S_EMRD;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        n_ovalid = w_load ? 1'b1 : (o_rsp.ready ? 1'b0 : r_ovalid);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
            r_used   <= '0;
            r_total  <= '0;
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
            r_used   <= n_used;
            r_total  <= n_total;
            if (w_we) begin
                r_vld[r_idx] <= 1'b1;
            end
            if (w_re) begin
                r_rd_vld <= r_vld[w_raddr];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx      <= n_idx;
        r_dispense <= n_dispense;
        r_walk     <= n_walk;
        r_neg      <= n_neg;
        r_rem      <= n_rem;
        r_dep      <= n_dep;
        r_take     <= n_take;
        r_cnt      <= n_cnt;
        if (w_load) begin
            r_o_status <= w_ld_status;
            r_o_index  <= w_ld_index;
            r_o_given  <= w_ld_given;
            r_o_left   <= w_ld_left;
            r_o_total  <= r_total;
            r_o_last   <= w_ld_last;
        end
    end

    // note count memory
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_cnt_mem[r_idx] <= w_wdata;
        end
        if (w_re) begin
            r_rd_cnt <= r_cnt_mem[w_raddr];
        end
    end

    // notes taken per denomination during a dispense
    always_ff @(posedge i_clk) begin
        if (w_tk_we) begin
            r_tk_mem[r_idx] <= r_take;
        end
        if (w_tk_re) begin
            r_tk_rd <= r_tk_mem[w_hi];
        end
    end

`ifndef SYNTHESIS
    a_emit_has_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMRD || r_state == S_EMWR) |-> (r_used != '0))
        else $error("result walk with no denomination pending");

    a_idle_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (r_used == '0))
        else $error("idle with dispensed denominations not reported");

    a_take_le_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SUB) |-> (CMP_W'(r_take) <= CMP_W'(r_cnt)))
        else $error("take exceeds the stored count");

    a_rem_falls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SUB) |=> (r_rem <= $past(r_rem)))
        else $error("remaining change grew during the walk");
`endif

endmodule
